FILE: rtl/sthg_pkg.sv
// Shared types and constants of the stencil histogram traffic generator.
`default_nettype none
package sthg_pkg;

	localparam int RAND_BITS   = 32;
	localparam int LIMIT_BITS  = 16;
	localparam int MESH_BITS   = 11;
	localparam int CORNER_BITS = 30;
	localparam int ADDR_BITS   = 34;
	localparam int IDX_BITS    = ADDR_BITS - 3;
	localparam int PLANE_BITS  = 2 * MESH_BITS;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = CORNER_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MESH_X       = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MESH_Y       = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HISTO_SLOTS  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEGIN_CORNER = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_END_CORNER   = 3'd5;

	localparam logic [LIMIT_BITS-1:0]  ITER_LIMIT_RESET   = 16'd1;
	localparam logic [MESH_BITS-1:0]   MESH_X_RESET       = 11'd32;
	localparam logic [MESH_BITS-1:0]   MESH_Y_RESET       = 11'd32;
	localparam logic [MESH_BITS-1:0]   HISTO_SLOTS_RESET  = 11'd32;
	localparam logic [CORNER_BITS-1:0] BEGIN_CORNER_RESET = 30'd1049601;
	localparam logic [CORNER_BITS-1:0] END_CORNER_RESET   = 30'd31488030;

	// request slots of one stencil run
	localparam int STEP_BITS = 3;
	localparam logic [STEP_BITS-1:0] STEP_CENTER = 3'd0;
	localparam logic [STEP_BITS-1:0] STEP_XP     = 3'd1;
	localparam logic [STEP_BITS-1:0] STEP_XM     = 3'd2;
	localparam logic [STEP_BITS-1:0] STEP_YP     = 3'd3;
	localparam logic [STEP_BITS-1:0] STEP_YM     = 3'd4;
	localparam logic [STEP_BITS-1:0] STEP_ZP     = 3'd5;
	localparam logic [STEP_BITS-1:0] STEP_ZM     = 3'd6;
	localparam logic [STEP_BITS-1:0] STEP_HISTO  = 3'd7;

	// remainder unit: dividend bits retired per cycle
	localparam int MOD_STEP_BITS = 4;
	localparam int MOD_ITERS     = RAND_BITS / MOD_STEP_BITS;

	localparam int QUEUE_DEPTH = 2;

	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef struct packed {
		logic [LIMIT_BITS-1:0]  iteration_limit;
		logic [MESH_BITS-1:0]   mesh_x;
		logic [MESH_BITS-1:0]   mesh_y;
		logic [MESH_BITS-1:0]   histo_slots;
		logic [CORNER_BITS-1:0] begin_corner;
		logic [CORNER_BITS-1:0] end_corner;
	} cfg_regs_t;

endpackage
`default_nettype wire

FILE: rtl/sthg_mod.sv
// Multi-cycle remainder unit: random word modulo histogram slot count.
`default_nettype none
module sthg_mod (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [sthg_pkg::RAND_BITS-1:0]  dividend,
	input  wire logic [sthg_pkg::MESH_BITS-1:0]  divisor,
	output logic                                 done,
	output logic [sthg_pkg::MESH_BITS-1:0]       rem
);
	import sthg_pkg::*;

	localparam int CNT_BITS = $clog2(MOD_ITERS);

	logic [RAND_BITS-1:0] num_q;
	logic [MESH_BITS-1:0] den_q;
	logic [MESH_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MESH_BITS-1:0] rem_next;

	// restoring steps, one dividend bit each
	always_comb begin
		logic [MESH_BITS:0]   t;
		logic [MESH_BITS-1:0] r;
		r = rem_q;
		for (int i = 0; i < MOD_STEP_BITS; i++) begin
			t = {r, num_q[RAND_BITS-1-i]};
			if (t >= {1'b0, den_q})
				t = t - {1'b0, den_q};
			r = t[MESH_BITS-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(MOD_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << MOD_STEP_BITS;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	// zero slots sends the write to slot 0
	assign rem  = (den_q == '0) ? '0 : rem_q;

endmodule
`default_nettype wire

FILE: rtl/sthg_queue.sv
// Short command queue between the walk front end and the request back end.
`default_nettype none
module sthg_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      head
);
	import sthg_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign full      = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

FILE: rtl/sthg_front.sv
// Front end: takes random words, advances the mesh walk and sweep state, queues commands.
`default_nettype none
module sthg_front #(
	parameter int COORD_BITS = 10,
	parameter int SLOT_BITS  = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sthg_pkg::cfg_regs_t               cfg,
	input  wire logic                              rand_valid,
	output logic                                   rand_ready,
	input  wire logic [sthg_pkg::RAND_BITS-1:0]    rand_word,
	input  wire logic                              queue_full,
	output logic                                   push,
	output logic [1 + sthg_pkg::RAND_BITS + 3 * (COORD_BITS + 1) + SLOT_BITS - 1:0] cmd
);
	import sthg_pkg::*;

	localparam int CW = COORD_BITS + 1;
	localparam int PW = 3 * COORD_BITS;
	localparam logic [PW-1:0] BEG_RST = PW'(BEGIN_CORNER_RESET);

	logic [CW-1:0]         cur_x_q, cur_y_q, cur_z_q;
	logic [LIMIT_BITS-1:0] sweep_q;
	logic [1:0]            sweep_mod3_q;
	logic [SLOT_BITS-1:0]  ptr_q;
	logic                  phase_q;

	logic [PW-1:0] beg_w, end_w;
	logic [CW-1:0] bx, by, bz, ex, ey, ez;
	logic [CW-1:0] wx, wy, wz;
	logic          accept, finished, at_end;
	logic [1:0]    mod3_next;
	logic [SLOT_BITS-1:0] ptr_inc;

	assign beg_w = PW'(cfg.begin_corner);
	assign end_w = PW'(cfg.end_corner);
	assign bx = CW'(beg_w[0 +: COORD_BITS]);
	assign by = CW'(beg_w[COORD_BITS +: COORD_BITS]);
	assign bz = CW'(beg_w[2*COORD_BITS +: COORD_BITS]);
	assign ex = CW'(end_w[0 +: COORD_BITS]);
	assign ey = CW'(end_w[COORD_BITS +: COORD_BITS]);
	assign ez = CW'(end_w[2*COORD_BITS +: COORD_BITS]);

	assign rand_ready = !queue_full;
	assign accept     = rand_valid && rand_ready;
	assign finished   = (sweep_q == cfg.iteration_limit);
	assign at_end     = (cur_x_q == ex) && (cur_y_q == ey) && (cur_z_q == ez);
	assign push       = accept && !finished && !at_end;

	// row and plane wrap before the point is used
	always_comb begin
		wx = cur_x_q;
		wy = cur_y_q;
		wz = cur_z_q;
		if (cur_x_q > ex) begin
			wx = bx;
			if (cur_y_q < ey) begin
				wy = cur_y_q + 1'b1;
			end else begin
				wy = by;
				wz = cur_z_q + 1'b1;
			end
		end
	end

	// sweep count mod 3, with the 16-bit wrap back to zero
	assign mod3_next = (sweep_q == '1) ? 2'd0 :
	                   (sweep_mod3_q == 2'd2) ? 2'd0 : sweep_mod3_q + 2'd1;
	assign ptr_inc   = ptr_q + 1'b1;

	assign cmd = {phase_q, rand_word, wx, wy, wz, ptr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= CW'(BEG_RST[0 +: COORD_BITS]);
			cur_y_q      <= CW'(BEG_RST[COORD_BITS +: COORD_BITS]);
			cur_z_q      <= CW'(BEG_RST[2*COORD_BITS +: COORD_BITS]);
			sweep_q      <= '0;
			sweep_mod3_q <= 2'd0;
			ptr_q        <= '0;
			phase_q      <= 1'b0;
		end else if (accept && !finished) begin
			if (at_end) begin
				sweep_q      <= sweep_q + 1'b1;
				sweep_mod3_q <= mod3_next;
				phase_q      <= (mod3_next == 2'd2);
				ptr_q        <= '0;
				cur_x_q      <= bx;
				cur_y_q      <= by;
				cur_z_q      <= bz;
			end else begin
				cur_x_q <= wx + 1'b1;
				cur_y_q <= wy;
				cur_z_q <= wz;
				if (phase_q) begin
					if ({{MESH_BITS{1'b0}}, ptr_inc} == {{SLOT_BITS{1'b0}}, cfg.histo_slots})
						ptr_q <= '0;
					else
						ptr_q <= ptr_inc;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sthg_back.sv
// Back end: turns queued commands into runs of read and write request words.
`default_nettype none
module sthg_back #(
	parameter int COORD_BITS = 10,
	parameter int SLOT_BITS  = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sthg_pkg::cfg_regs_t               cfg,
	input  wire logic                              cmd_valid,
	input  wire logic [1 + sthg_pkg::RAND_BITS + 3 * (COORD_BITS + 1) + SLOT_BITS - 1:0] cmd,
	output logic                                   cmd_pop,
	output logic                                   req_valid,
	input  wire logic                              req_ready,
	output logic                                   is_write,
	output logic [sthg_pkg::ADDR_BITS-1:0]         address,
	output logic                                   after_reads,
	output logic                                   last
);
	import sthg_pkg::*;

	localparam int CW = COORD_BITS + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]           state_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 histo_q, odd_q;
	logic [CW-1:0]        x_q, y_q, z_q;
	logic [SLOT_BITS-1:0] ptr_q;
	logic [PLANE_BITS-1:0] plane_q;
	idx_t                 zp_s1, ym_s1;
	idx_t                 center_q;

	logic                 req_valid_q, is_write_q, after_reads_q, last_q;
	addr_t                address_q;

	logic                 c_histo;
	logic [RAND_BITS-1:0] c_rand;
	logic [CW-1:0]        c_x, c_y, c_z;
	logic [SLOT_BITS-1:0] c_ptr;

	logic [CW+PLANE_BITS-1:0] zp_full;
	logic [CW+MESH_BITS-1:0]  ym_full;

	logic                 div_done;
	logic [MESH_BITS-1:0] slot;

	idx_t  delta, nbr_idx;
	logic  delta_neg;
	logic  n_write, n_dep, n_last;
	addr_t n_addr;
	logic  emit;

	assign {c_histo, c_rand, c_x, c_y, c_z, c_ptr} = cmd;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	sthg_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd_pop && !c_histo),
		.dividend (c_rand),
		.divisor  (cfg.histo_slots),
		.done     (div_done),
		.rem      (slot)
	);

	assign zp_full = z_q * plane_q;
	assign ym_full = y_q * cfg.mesh_x;

	// neighbor offsets from the center index
	always_comb begin
		delta     = '0;
		delta_neg = 1'b0;
		case (step_q)
			STEP_CENTER: delta = '0;
			STEP_XP:     delta = idx_t'(1);
			STEP_XM:     begin delta = idx_t'(1);           delta_neg = 1'b1; end
			STEP_YP:     delta = idx_t'(cfg.mesh_x);
			STEP_YM:     begin delta = idx_t'(cfg.mesh_x);  delta_neg = 1'b1; end
			STEP_ZP:     delta = idx_t'(plane_q);
			STEP_ZM:     begin delta = idx_t'(plane_q);     delta_neg = 1'b1; end
			default:     delta = '0;
		endcase
	end

	assign nbr_idx = delta_neg ? center_q - delta : center_q + delta;

	always_comb begin
		n_write = 1'b0;
		n_dep   = 1'b0;
		n_last  = 1'b0;
		n_addr  = {nbr_idx, 3'b000};
		if (histo_q) begin
			if (step_q == STEP_CENTER) begin
				n_addr = addr_t'({ptr_q, 3'b000});
				n_last = !odd_q;
			end else begin
				n_write = 1'b1;
				n_dep   = 1'b1;
				n_last  = 1'b1;
				n_addr  = {center_q, 3'b000};
			end
		end else if (step_q == STEP_HISTO) begin
			n_write = 1'b1;
			n_dep   = 1'b1;
			n_last  = 1'b1;
			n_addr  = addr_t'({slot, 3'b000});
		end
	end

	assign emit = (state_q == ST_EMIT) && (!req_valid_q || req_ready) &&
	              (histo_q || step_q != STEP_HISTO || div_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_CENTER;
			req_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd_valid) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_EMIT;
					step_q  <= STEP_CENTER;
				end
				ST_EMIT: if (emit) begin
					if (n_last)
						state_q <= ST_IDLE;
					else
						step_q <= step_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit)
				req_valid_q <= 1'b1;
			else if (req_ready)
				req_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		plane_q <= cfg.mesh_x * cfg.mesh_y;
		if (cmd_pop) begin
			histo_q <= c_histo;
			odd_q   <= c_rand[0];
			x_q     <= c_x;
			y_q     <= c_y;
			z_q     <= c_z;
			ptr_q   <= c_ptr;
		end
		if (state_q == ST_MUL) begin
			zp_s1 <= idx_t'(zp_full);
			ym_s1 <= idx_t'(ym_full);
		end
		if (state_q == ST_SUM)
			center_q <= idx_t'(cfg.histo_slots) + zp_s1 + ym_s1 + idx_t'(x_q);
		if (emit) begin
			is_write_q    <= n_write;
			address_q     <= n_addr;
			after_reads_q <= n_dep;
			last_q        <= n_last;
		end
	end

	assign req_valid   = req_valid_q;
	assign is_write    = is_write_q;
	assign address     = address_q;
	assign after_reads = after_reads_q;
	assign last        = last_q;

endmodule
`default_nettype wire

FILE: rtl/stencil_histogram_traffic_generator.sv
// Top level: configuration registers, walk front end, command queue and request back end.
//
// Each accepted random word advances a walk over a 3D box of a mesh and becomes a run of
// 8-byte requests: seven stencil reads and one histogram write (slot = word mod histo_slots),
// or, in every third sweep, one histogram read and on an odd word one mesh write. The front
// end takes a word per cycle while its two-entry command queue has room; words that emit
// nothing (end of sweep, or all sweeps done) finish there. The back end handles one command
// at a time: it pops a command, forms the center address (multiply, then sum), then emits
// one request per cycle while the request side takes them. The slot remainder comes from a
// 4-bit-per-cycle divider started at pop, which is done before the last request is due.
// Register writes are to be made only while the block is idle; the block itself does not
// enforce it. A corner change takes effect at the next walk step.
`default_nettype none
module stencil_histogram_traffic_generator #(
	parameter int COORD_BITS = 10,
	parameter int SLOT_BITS  = 10
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_write,
	input  wire logic [sthg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [sthg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                  rand_valid,
	output logic                                       rand_ready,
	input  wire logic [sthg_pkg::RAND_BITS-1:0]        rand_word,
	output logic                                       req_valid,
	input  wire logic                                  req_ready,
	output logic                                       is_write,
	output logic [sthg_pkg::ADDR_BITS-1:0]             address,
	output logic                                       after_reads,
	output logic                                       last
);
	import sthg_pkg::*;

	localparam int CMD_W = 1 + RAND_BITS + 3 * (COORD_BITS + 1) + SLOT_BITS;

	cfg_regs_t        cfg_q;
	logic             push, pop, full, not_empty;
	logic [CMD_W-1:0] front_cmd, head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iteration_limit <= ITER_LIMIT_RESET;
			cfg_q.mesh_x          <= MESH_X_RESET;
			cfg_q.mesh_y          <= MESH_Y_RESET;
			cfg_q.histo_slots     <= HISTO_SLOTS_RESET;
			cfg_q.begin_corner    <= BEGIN_CORNER_RESET;
			cfg_q.end_corner      <= END_CORNER_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ITER_LIMIT:   cfg_q.iteration_limit <= cfg_data[LIMIT_BITS-1:0];
				REG_MESH_X:       cfg_q.mesh_x          <= cfg_data[MESH_BITS-1:0];
				REG_MESH_Y:       cfg_q.mesh_y          <= cfg_data[MESH_BITS-1:0];
				REG_HISTO_SLOTS:  cfg_q.histo_slots     <= cfg_data[MESH_BITS-1:0];
				REG_BEGIN_CORNER: cfg_q.begin_corner    <= cfg_data[CORNER_BITS-1:0];
				REG_END_CORNER:   cfg_q.end_corner      <= cfg_data[CORNER_BITS-1:0];
				default: ;
			endcase
		end
	end

	sthg_front #(
		.COORD_BITS (COORD_BITS),
		.SLOT_BITS  (SLOT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.rand_valid (rand_valid),
		.rand_ready (rand_ready),
		.rand_word  (rand_word),
		.queue_full (full),
		.push       (push),
		.cmd        (front_cmd)
	);

	sthg_queue #(
		.WIDTH (CMD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head_cmd)
	);

	sthg_back #(
		.COORD_BITS (COORD_BITS),
		.SLOT_BITS  (SLOT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_valid   (not_empty),
		.cmd         (head_cmd),
		.cmd_pop     (pop),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.is_write    (is_write),
		.address     (address),
		.after_reads (after_reads),
		.last        (last)
	);

endmodule
`default_nettype wire
